// ===== sv/pwc_pkg.sv =====
// pwc_pkg: request and result types for the pulse width capture block
// no dependencies; used by pwc_track and pulse_width_capture
package pwc_pkg;

    localparam int CAPTURE_BITS = 16;
    localparam int WRAP_OUT_BITS = 12;

    typedef struct packed {
        logic                    overflow_event;
        logic                    capture_event;
        logic [CAPTURE_BITS-1:0] captured_count;
    } item_t;

    typedef struct packed {
        logic                     measure_done;
        logic                     pulse_high;
        logic                     overflow_saturated;
        logic [WRAP_OUT_BITS-1:0] overflow_count;
        logic [CAPTURE_BITS-1:0]  rising_count;
        logic [CAPTURE_BITS-1:0]  falling_count;
        logic                     edge_select;
    } result_t;

endpackage

// ===== sv/pwc_track.sv =====
// pwc_track: measurement state registers and their single-pass update
// depends on pwc_pkg for the request and result types
module pwc_track #(
    parameter int COUNT_BITS      = 16,
    parameter int WRAP_COUNT_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  pwc_pkg::item_t   item,
    output pwc_pkg::result_t result
);

    localparam int VAL_BITS = (COUNT_BITS < pwc_pkg::CAPTURE_BITS) ?
                              COUNT_BITS : pwc_pkg::CAPTURE_BITS;
    localparam logic [WRAP_COUNT_BITS-1:0] WRAP_MAX = {WRAP_COUNT_BITS{1'b1}};

    logic [WRAP_COUNT_BITS-1:0] count_reg, count_next;
    logic                       sat_reg, sat_next;
    logic                       high_reg, high_next;
    logic                       done_reg, done_next;
    logic [VAL_BITS-1:0]        rising_reg, rising_next;
    logic [VAL_BITS-1:0]        falling_reg, falling_next;
    logic                       polarity_reg, polarity_next;
    logic [VAL_BITS-1:0]        value;

    assign value = item.captured_count[VAL_BITS-1:0];

    always_comb
    begin
        count_next    = count_reg;
        sat_next      = sat_reg;
        high_next     = high_reg;
        done_next     = done_reg;
        rising_next   = rising_reg;
        falling_next  = falling_reg;
        polarity_next = polarity_reg;

        // wraps only count while the pulse is high
        if (item.overflow_event && high_reg)
        begin
            if (count_reg == WRAP_MAX)
                sat_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
        end

        if (item.capture_event)
        begin
            // a held result is dropped before a new edge
            if (done_reg)
            begin
                count_next   = '0;
                sat_next     = 1'b0;
                high_next    = 1'b0;
                done_next    = 1'b0;
                rising_next  = '0;
                falling_next = '0;
            end
            if (!high_next)
            begin
                rising_next   = value;
                high_next     = 1'b1;
                polarity_next = 1'b1;
            end
            else
            begin
                falling_next  = value;
                high_next     = 1'b0;
                done_next     = 1'b1;
                polarity_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sat_reg      <= 1'b0;
            high_reg     <= 1'b0;
            done_reg     <= 1'b0;
            rising_reg   <= '0;
            falling_reg  <= '0;
            polarity_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            sat_reg      <= sat_next;
            high_reg     <= high_next;
            done_reg     <= done_next;
            rising_reg   <= rising_next;
            falling_reg  <= falling_next;
            polarity_reg <= polarity_next;
        end
    end

    always_comb
    begin
        result.measure_done       = done_next;
        result.pulse_high         = high_next;
        result.overflow_saturated = sat_next;
        result.overflow_count     = pwc_pkg::WRAP_OUT_BITS'(count_next);
        result.rising_count       = pwc_pkg::CAPTURE_BITS'(rising_next);
        result.falling_count      = pwc_pkg::CAPTURE_BITS'(falling_next);
        result.edge_select        = polarity_next;
    end

endmodule

// ===== sv/pulse_width_capture.sv =====
// pulse_width_capture: top level, request register, state update, result register
// depends on pwc_pkg and pwc_track
//
// channel   direction  handshake                    payload
// request   in         item_valid / item_stall      item   (pwc_pkg::item_t)
// result    out        result_valid / result_stall  result (pwc_pkg::result_t)
//
// one request per cycle sustained while result_stall is low; each gives one result
// via the request register, then the state update into the result register
// rst_n clears all measurement state and both valid flags asynchronously
// a stalled result holds in its register; the request register still fills,
// and item_stall rises only when both registers are full and result_stall is high
module pulse_width_capture #(
    parameter int COUNT_BITS      = 16,
    parameter int WRAP_COUNT_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pwc_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pwc_pkg::result_t result
);

    logic             req_valid_reg;
    pwc_pkg::item_t   req_reg;
    logic             out_valid_reg;
    pwc_pkg::result_t out_reg;
    pwc_pkg::result_t result_next;
    logic             out_free;
    logic             advance;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = req_valid_reg && out_free;
    assign item_stall = req_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (!item_stall)
            req_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            req_reg <= item;
    end

    pwc_track #(
        .COUNT_BITS      (COUNT_BITS),
        .WRAP_COUNT_BITS (WRAP_COUNT_BITS)
    ) u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (req_reg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== test/tb_pulse_width_capture.sv =====
// tb_pulse_width_capture: self-checking testbench for the pulse width capture block
// depends on pwc_pkg and pulse_width_capture; runs directed and random phases
// with random valid gaps and result stalls, checked against a built-in pulse tracker
module tb_pulse_width_capture;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    pwc_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    pwc_pkg::result_t result;

    pwc_pkg::item_t   pending_reqs[$];
    pwc_pkg::result_t expected_results[$];
    pwc_pkg::result_t want;

    // tracker state
    logic [pwc_pkg::WRAP_OUT_BITS-1:0] wrap_cnt = '0;
    logic                              sat_flag = 1'b0;
    logic                              high_flag = 1'b0;
    logic                              done_flag = 1'b0;
    logic [pwc_pkg::CAPTURE_BITS-1:0]  rise_val = '0;
    logic [pwc_pkg::CAPTURE_BITS-1:0]  fall_val = '0;
    logic                              edge_falling = 1'b0;

    bit          idle_on = 1'b1;
    int unsigned reqs_sent = 0;
    int unsigned results_seen = 0;
    int unsigned done_seen = 0;
    int unsigned sat_seen = 0;
    int unsigned bad_results = 0;

    pulse_width_capture dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic pwc_pkg::result_t track_pulse(pwc_pkg::item_t req);
        pwc_pkg::result_t r;
        if (req.overflow_event && high_flag)
        begin
            if (wrap_cnt == {pwc_pkg::WRAP_OUT_BITS{1'b1}})
                sat_flag = 1'b1;
            else
                wrap_cnt = wrap_cnt + 1'b1;
        end
        if (req.capture_event)
        begin
            if (done_flag)
            begin
                wrap_cnt = '0;
                sat_flag = 1'b0;
                high_flag = 1'b0;
                done_flag = 1'b0;
                rise_val = '0;
                fall_val = '0;
            end
            if (!high_flag)
            begin
                rise_val = req.captured_count;
                high_flag = 1'b1;
                edge_falling = 1'b1;
            end
            else
            begin
                fall_val = req.captured_count;
                high_flag = 1'b0;
                done_flag = 1'b1;
                edge_falling = 1'b0;
            end
        end
        r.measure_done = done_flag;
        r.pulse_high = high_flag;
        r.overflow_saturated = sat_flag;
        r.overflow_count = wrap_cnt;
        r.rising_count = rise_val;
        r.falling_count = fall_val;
        r.edge_select = edge_falling;
        return r;
    endfunction

    function automatic string field_diff(pwc_pkg::result_t got, pwc_pkg::result_t exp);
        string s;
        s = "";
        if (got.measure_done !== exp.measure_done) s = {s, " measure_done"};
        if (got.pulse_high !== exp.pulse_high) s = {s, " pulse_high"};
        if (got.overflow_saturated !== exp.overflow_saturated) s = {s, " overflow_saturated"};
        if (got.overflow_count !== exp.overflow_count) s = {s, " overflow_count"};
        if (got.rising_count !== exp.rising_count) s = {s, " rising_count"};
        if (got.falling_count !== exp.falling_count) s = {s, " falling_count"};
        if (got.edge_select !== exp.edge_select) s = {s, " edge_select"};
        return s;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(track_pulse(item));
                reqs_sent++;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_reqs.size() != 0 && !(idle_on && $urandom_range(99) < 33))
                begin
                    item <= pending_reqs.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (result.measure_done) done_seen++;
                if (result.overflow_saturated) sat_seen++;
                if (expected_results.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("error: result with nothing expected: %p", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (field_diff(result, want) != "")
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("error: mismatch in%s\n  expected %p\n  actual   %p",
                                     field_diff(result, want), want, result);
                    end
                end
            end
            result_stall <= idle_on && ($urandom_range(99) < 33);
        end
    end

    task automatic add_req(bit ovf, bit cap, logic [pwc_pkg::CAPTURE_BITS-1:0] val);
        pwc_pkg::item_t r;
        r.overflow_event = ovf;
        r.capture_event = cap;
        r.captured_count = val;
        pending_reqs.push_back(r);
    endtask

    // hold the sender until every queued request is in and every result is back
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || item_valid) @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    task automatic run_random(int n);
        int made;
        int k;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(9) < 7)
            begin
                // one measurement: rising capture, overflows and quiet items, falling capture
                add_req(1'($urandom_range(1)), 1'b1, pwc_pkg::CAPTURE_BITS'($urandom));
                k = $urandom_range(12);
                if ($urandom_range(15) == 0) k = $urandom_range(60, 300);
                if (k > n - made) k = n - made;
                repeat (k)
                    add_req($urandom_range(3) != 0, 1'b0, pwc_pkg::CAPTURE_BITS'($urandom));
                add_req(1'($urandom_range(1)), 1'b1, pwc_pkg::CAPTURE_BITS'($urandom));
                made += k + 2;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                    add_req(1'($urandom_range(1)), 1'($urandom_range(1)),
                            pwc_pkg::CAPTURE_BITS'($urandom));
                made += k;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // edge cases
        add_req(1'b0, 1'b0, 16'h0000);
        add_req(1'b1, 1'b0, 16'hFFFF);  // overflow while low
        add_req(1'b0, 1'b1, 16'h0000);  // rising edge
        add_req(1'b1, 1'b0, 16'h5555);
        add_req(1'b1, 1'b0, 16'hAAAA);
        add_req(1'b1, 1'b1, 16'hFFFF);  // overflow then falling edge
        add_req(1'b1, 1'b0, 16'h0001);  // overflow after done
        add_req(1'b0, 1'b0, 16'h8000);
        add_req(1'b0, 1'b1, 16'hFFFF);  // capture while done clears first
        add_req(1'b0, 1'b1, 16'h0000);
        add_req(1'b1, 1'b1, 16'h8001);  // both events while done
        add_req(1'b1, 1'b0, 16'h1234);
        add_req(1'b0, 1'b1, 16'h7FFE);
        drain();

        // back-to-back stretch with no gaps or stalls
        idle_on = 1'b0;
        run_random(120);
        drain();
        idle_on = 1'b1;
        run_random(315);
        drain();

        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            bad_results++;
            $display("error: %0d results never arrived", expected_results.size());
        end
        $display("run covered %0d requests and %0d checked results", reqs_sent, results_seen);
        $display("  %0d results with a finished measurement, %0d with the count saturated",
                 done_seen, sat_seen);
        if (bad_results == 0)
            $display("PASS pulse_width_capture");
        else
            $display("FAIL pulse_width_capture");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout: %0d requests pending, %0d results outstanding",
                 pending_reqs.size(), expected_results.size());
        $display("FAIL pulse_width_capture");
        $finish;
    end

endmodule
